/* hdl/sppc_pkg.sv */
// Package for the sensor packet parity checker.
// Holds the status codes, lane and decision structs, and fixed constants.
// No dependencies.
`default_nettype none

package sppc_pkg;

   localparam int unsigned LANES = 4;

   typedef enum logic [2:0] {
      STATUS_STORED    = 3'd0,
      STATUS_EMERGENCY = 3'd1,
      STATUS_FOREIGN   = 3'd2,
      STATUS_PARITY    = 3'd3,
      STATUS_READ      = 3'd4
   } status_type;

   localparam logic [3:0] ACK_NIBBLE = 4'hE;  // parity flags of 0,0,0,0x32
   localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

   // per-byte findings of one lane
   typedef struct packed {
      logic even;
      logic zero;
      logic ones;
   } lane_flags_type;

   // merged verdict for a packet
   typedef struct packed {
      status_type status;
      logic       store_en;
      logic       send_ack;
   } verdict_type;

endpackage

`default_nettype wire

/* hdl/sppc_if.sv */
// Channel interfaces for the sensor packet parity checker.
// Request and response valid/ready channels; no dependencies.
`default_nettype none

interface sppc_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] header;
   logic [7:0] byte_x;
   logic [7:0] byte_y;
   logic [7:0] byte_z;
   logic [7:0] byte_t;
   logic [3:0] query_id;

   modport source (output valid, mode, header, byte_x, byte_y, byte_z, byte_t, query_id,
                   input ready);
   modport sink   (input valid, mode, header, byte_x, byte_y, byte_z, byte_t, query_id,
                   output ready);
endinterface

interface sppc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [3:0] sensor_id;
   logic       send_ack;
   logic [7:0] ack_header;
   logic [7:0] out_x;
   logic [7:0] out_y;
   logic [7:0] out_z;
   logic [7:0] out_t;

   modport source (output valid, status, sensor_id, send_ack, ack_header,
                   out_x, out_y, out_z, out_t, input ready);
   modport sink   (input valid, status, sensor_id, send_ack, ack_header,
                   out_x, out_y, out_z, out_t, output ready);
endinterface

`default_nettype wire

/* hdl/sppc_lane.sv */
// One byte lane: even-parity flag, zero and all-ones detection.
// Depends on sppc_pkg.
`default_nettype none

module sppc_lane (
   input  wire logic [7:0]             data,
   output sppc_pkg::lane_flags_type    flags
);
   import sppc_pkg::*;

   always_comb begin
      flags.even = ~(^data);
      flags.zero = (data == 8'h00);
      flags.ones = (data == BYTE_ALL_ONES);
   end

endmodule

`default_nettype wire

/* hdl/sppc_merge.sv */
// Merge stage: combines the four lane results with the header and the mode into a verdict.
// Depends on sppc_pkg.
`default_nettype none

module sppc_merge (
   input  wire logic                   mode,
   input  wire logic [7:0]             header,
   input  wire sppc_pkg::lane_flags_type lane_flags [sppc_pkg::LANES],
   output sppc_pkg::verdict_type       verdict
);
   import sppc_pkg::*;

   logic [3:0] parity_nibble;
   logic       foreign;
   logic       any_ones;

   always_comb begin
      // x lane gives bit 3 down to t lane at bit 0
      parity_nibble = {lane_flags[0].even, lane_flags[1].even,
                       lane_flags[2].even, lane_flags[3].even};
      foreign  = lane_flags[1].zero && lane_flags[2].zero &&
                 ((header == 8'h00) || lane_flags[3].zero);
      any_ones = lane_flags[0].ones || lane_flags[1].ones ||
                 lane_flags[2].ones || lane_flags[3].ones;

      verdict.store_en = 1'b0;
      verdict.send_ack = 1'b0;
      if (mode) begin
         verdict.status = STATUS_READ;
      end else if (parity_nibble != header[3:0]) begin
         verdict.status = STATUS_PARITY;
      end else if (foreign) begin
         verdict.status = STATUS_FOREIGN;
      end else if (any_ones) begin
         verdict.status   = STATUS_EMERGENCY;
         verdict.send_ack = 1'b1;
      end else begin
         verdict.status   = STATUS_STORED;
         verdict.store_en = 1'b1;
      end
   end

endmodule

`default_nettype wire

/* hdl/sensor_packet_parity_checker_unit.sv */
// Sensor packet parity checker, top level.
// The result is registered and presented the cycle after the request transaction.
// Throughput: one transaction per cycle unless the response channel stalls; four byte lanes
// and the merge stage decide combinationally, and the table is read and written in flip-flops.
// Reset (synchronous) clears the sensor table and the result valid flag at once.
// Depends on sppc_pkg, sppc_if, sppc_lane, sppc_merge.
`default_nettype none

module sensor_packet_parity_checker_unit #(
   parameter int unsigned SENSOR_SLOTS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   sppc_req_if.sink     req_chan,
   sppc_rsp_if.source   rsp_chan
);
   import sppc_pkg::*;

   localparam int unsigned IDX_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

   logic [7:0]     lane_data  [LANES];
   lane_flags_type lane_flags [LANES];
   verdict_type    verdict;

   logic [31:0]    sensor_table_ff [SENSOR_SLOTS];

   logic           accept;
   logic [3:0]     pkt_id;
   logic           pkt_slot_ok;
   logic           qry_slot_ok;
   logic [IDX_W-1:0] pkt_idx;
   logic [IDX_W-1:0] qry_idx;
   logic [31:0]    pkt_word;
   logic [31:0]    read_word;

   logic           rsp_valid_ff, rsp_valid_in;
   status_type     status_ff,    status_in;
   logic [3:0]     sensor_id_ff, sensor_id_in;
   logic           send_ack_ff,  send_ack_in;
   logic [7:0]     ack_header_ff, ack_header_in;
   logic [31:0]    out_word_ff,  out_word_in;

   assign lane_data[0] = req_chan.byte_x;
   assign lane_data[1] = req_chan.byte_y;
   assign lane_data[2] = req_chan.byte_z;
   assign lane_data[3] = req_chan.byte_t;

   for (genvar g = 0; g < LANES; g++) begin : gen_lane
      sppc_lane u_lane (
         .data  (lane_data[g]),
         .flags (lane_flags[g])
      );
   end

   sppc_merge u_merge (
      .mode       (req_chan.mode),
      .header     (req_chan.header),
      .lane_flags (lane_flags),
      .verdict    (verdict)
   );

   // output register frees up whenever its transaction is taken
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign pkt_id      = req_chan.header[7:4];
   assign pkt_slot_ok = ({1'b0, pkt_id} < 5'(SENSOR_SLOTS));
   assign qry_slot_ok = ({1'b0, req_chan.query_id} < 5'(SENSOR_SLOTS));
   assign pkt_idx     = IDX_W'(pkt_id);
   assign qry_idx     = IDX_W'(req_chan.query_id);
   assign pkt_word    = {req_chan.byte_t, req_chan.byte_z, req_chan.byte_y, req_chan.byte_x};
   assign read_word   = qry_slot_ok ? sensor_table_ff[qry_idx] : 32'h0;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      status_in     = status_ff;
      sensor_id_in  = sensor_id_ff;
      send_ack_in   = send_ack_ff;
      ack_header_in = ack_header_ff;
      out_word_in   = out_word_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         status_in     = verdict.status;
         sensor_id_in  = req_chan.mode ? req_chan.query_id : pkt_id;
         send_ack_in   = verdict.send_ack;
         ack_header_in = verdict.send_ack ? {pkt_id, ACK_NIBBLE} : 8'h00;
         out_word_in   = req_chan.mode ? read_word : 32'h0;
      end else if (rsp_chan.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      sensor_id_ff  <= sensor_id_in;
      send_ack_ff   <= send_ack_in;
      ack_header_ff <= ack_header_in;
      out_word_ff   <= out_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_SLOTS; i++) begin
            sensor_table_ff[i] <= 32'h0;
         end
      end else if (accept && verdict.store_en && pkt_slot_ok) begin
         sensor_table_ff[pkt_idx] <= pkt_word;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.sensor_id  = sensor_id_ff;
   assign rsp_chan.send_ack   = send_ack_ff;
   assign rsp_chan.ack_header = ack_header_ff;
   assign rsp_chan.out_x      = out_word_ff[7:0];
   assign rsp_chan.out_y      = out_word_ff[15:8];
   assign rsp_chan.out_z      = out_word_ff[23:16];
   assign rsp_chan.out_t      = out_word_ff[31:24];

   // a transaction always leaves a result behind
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   // a stored packet lands in its slot
   a_store_lands: assert property (@(posedge clock) disable iff (reset)
      (accept && verdict.store_en && pkt_slot_ok) |=>
         (sensor_table_ff[$past(pkt_idx)] == $past(pkt_word)))
      else $error("table entry does not match stored packet");

   // acknowledge only with emergency status and the fixed nibble
   a_ack_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && send_ack_ff) |->
         (status_ff == STATUS_EMERGENCY && ack_header_ff[3:0] == ACK_NIBBLE))
      else $error("acknowledge without emergency status");

   // data bytes only come back on a read reply
   a_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != STATUS_READ) |-> (out_word_ff == 32'h0))
      else $error("data bytes on a non-read result");

endmodule

`default_nettype wire

/* tb/tb_sensor_packet_parity_checker_unit.sv */
// Self-checking testbench for sensor_packet_parity_checker_unit: directed and random packets
// are checked against an in-bench predictor of the parity checks and the sensor table.
// Depends on sppc_pkg, sppc_if and the unit's RTL.
`timescale 1ns / 1ps

module tb_sensor_packet_parity_checker_unit;
   import sppc_pkg::*;

   localparam int unsigned SLOT_COUNT = 16;
   localparam logic MODE_CHECK = 1'b0;
   localparam logic MODE_READ  = 1'b1;
   localparam logic [7:0] ACK_TRAILER = 8'h32;
   localparam logic [7:0] BYTE_FULL   = 8'hFF;
   // ack header low nibble = even flags of the ack payload 0,0,0,0x32
   localparam logic [3:0] ACK_FLAGS = {~^8'h00, ~^8'h00, ~^8'h00, ~^ACK_TRAILER};
   localparam int unsigned PHASE_COUNT = 5;
   localparam int unsigned PHASE_ITEMS = 350;

   typedef struct packed {
      logic       mode;
      logic [7:0] header;
      logic [7:0] byte_x;
      logic [7:0] byte_y;
      logic [7:0] byte_z;
      logic [7:0] byte_t;
      logic [3:0] query_id;
   } packet_type;

   typedef struct packed {
      status_type status;
      logic [3:0] sensor_id;
      logic       send_ack;
      logic [7:0] ack_header;
      logic [7:0] out_x;
      logic [7:0] out_y;
      logic [7:0] out_z;
      logic [7:0] out_t;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sppc_req_if req_chan ();
   sppc_rsp_if rsp_chan ();

   sensor_packet_parity_checker_unit #(
      .SENSOR_SLOTS(SLOT_COUNT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   packet_type  packet_queue[$];
   result_type  expected_verdicts[$];
   logic [31:0] slot_mirror[SLOT_COUNT];
   packet_type  in_flight;
   result_type  want;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned fail_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor: one verdict per packet, updates the table mirror on a store
   function automatic result_type judge_packet(packet_type p);
      result_type v;
      logic [3:0] flags;
      v = '0;
      v.sensor_id = p.header[7:4];
      flags = {~^p.byte_x, ~^p.byte_y, ~^p.byte_z, ~^p.byte_t};
      if (p.mode == MODE_READ) begin
         v.status = STATUS_READ;
         v.sensor_id = p.query_id;
         if (p.query_id < SLOT_COUNT)
            {v.out_t, v.out_z, v.out_y, v.out_x} = slot_mirror[p.query_id];
      end else if (flags != p.header[3:0]) begin
         v.status = STATUS_PARITY;
      end else if (p.byte_y == 8'h00 && p.byte_z == 8'h00 &&
                   (p.header == 8'h00 || p.byte_t == 8'h00)) begin
         v.status = STATUS_FOREIGN;
      end else if (p.byte_x == BYTE_FULL || p.byte_y == BYTE_FULL ||
                   p.byte_z == BYTE_FULL || p.byte_t == BYTE_FULL) begin
         v.status = STATUS_EMERGENCY;
         v.send_ack = 1'b1;
         v.ack_header = {p.header[7:4], ACK_FLAGS};
      end else begin
         v.status = STATUS_STORED;
         if (p.header[7:4] < SLOT_COUNT)
            slot_mirror[p.header[7:4]] = {p.byte_t, p.byte_z, p.byte_y, p.byte_x};
      end
      return v;
   endfunction

   // well-formed packet: header low nibble carries the right parity flags
   function automatic packet_type make_packet(logic [3:0] id, logic [7:0] x, logic [7:0] y,
                                              logic [7:0] z, logic [7:0] t);
      packet_type p;
      p.mode = MODE_CHECK;
      p.header = {id, ~^x, ~^y, ~^z, ~^t};
      p.byte_x = x;
      p.byte_y = y;
      p.byte_z = z;
      p.byte_t = t;
      p.query_id = 4'($urandom_range(15));
      return p;
   endfunction

   function automatic packet_type make_read(logic [3:0] id);
      packet_type p;
      p.mode = MODE_READ;
      p.header = 8'($urandom_range(255));
      p.byte_x = 8'($urandom_range(255));
      p.byte_y = 8'($urandom_range(255));
      p.byte_z = 8'($urandom_range(255));
      p.byte_t = 8'($urandom_range(255));
      p.query_id = id;
      return p;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return BYTE_FULL;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic packet_type random_item();
      packet_type  p;
      logic [7:0]  x, y, z, t;
      logic [3:0]  id;
      int unsigned kind;
      kind = $urandom_range(99);
      id = 4'($urandom_range(15));
      x = pick_byte();
      y = pick_byte();
      z = pick_byte();
      t = pick_byte();
      if (kind < 15) begin
         p = make_read(id);
      end else if (kind < 23) begin
         // raw noise, nearly always a parity error
         p = make_read(id);
         p.mode = MODE_CHECK;
      end else if (kind < 33) begin
         p = make_packet(id, x, y, z, t);
         p.header[3:0] ^= 4'($urandom_range(1, 15));
      end else if (kind < 43) begin
         p = make_packet(id, x, 8'h00, 8'h00, 8'h00);
      end else if (kind < 53) begin
         case ($urandom_range(3))
            0:       x = BYTE_FULL;
            1:       y = BYTE_FULL;
            2:       z = BYTE_FULL;
            default: t = BYTE_FULL;
         endcase
         p = make_packet(id, x, y, z, t);
      end else begin
         p = make_packet(id, x, y, z, t);
      end
      return p;
   endfunction

   task automatic compare_field(string name, logic [7:0] expv, logic [7:0] actv);
      if (expv !== actv) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
         fail_count++;
      end
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (packet_queue.size() != 0 || req_chan.valid || expected_verdicts.size() != 0);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_verdicts.push_back(judge_packet(in_flight));
         if (!req_chan.valid || req_chan.ready) begin
            if (packet_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = packet_queue.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.mode     <= in_flight.mode;
               req_chan.header   <= in_flight.header;
               req_chan.byte_x   <= in_flight.byte_x;
               req_chan.byte_y   <= in_flight.byte_y;
               req_chan.byte_z   <= in_flight.byte_z;
               req_chan.byte_t   <= in_flight.byte_t;
               req_chan.query_id <= in_flight.query_id;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual status %0d",
                        $time, rsp_chan.status);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               compare_field("status", 8'(want.status), 8'(rsp_chan.status));
               compare_field("sensor_id", 8'(want.sensor_id), 8'(rsp_chan.sensor_id));
               compare_field("send_ack", 8'(want.send_ack), 8'(rsp_chan.send_ack));
               compare_field("ack_header", want.ack_header, rsp_chan.ack_header);
               compare_field("out_x", want.out_x, rsp_chan.out_x);
               compare_field("out_y", want.out_y, rsp_chan.out_y);
               compare_field("out_z", want.out_z, rsp_chan.out_z);
               compare_field("out_t", want.out_t, rsp_chan.out_t);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int unsigned phase_send[PHASE_COUNT];
      int unsigned phase_recv[PHASE_COUNT];
      packet_type p;
      phase_send = '{0, 70, 0, 30, 0};
      phase_recv = '{0, 0, 70, 30, 0};
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_CHECK;
      req_chan.header = 8'h00;
      req_chan.byte_x = 8'h00;
      req_chan.byte_y = 8'h00;
      req_chan.byte_z = 8'h00;
      req_chan.byte_t = 8'h00;
      req_chan.query_id = 4'h0;
      rsp_chan.ready = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++)
         slot_mirror[i] = 32'h0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // table is clear after reset
      packet_queue.push_back(make_read(4'h0));
      packet_queue.push_back(make_read(4'hF));
      // stores at both ends of the id range
      packet_queue.push_back(make_packet(4'h0, 8'h01, 8'h02, 8'h03, 8'h04));
      packet_queue.push_back(make_packet(4'hF, 8'hFE, 8'h80, 8'h7F, 8'h00));
      packet_queue.push_back(make_read(4'h0));
      packet_queue.push_back(make_read(4'hF));
      // parity errors, including an all-zero packet and a bad all-ones packet
      packet_queue.push_back('{MODE_CHECK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0});
      p = make_packet(4'h9, BYTE_FULL, BYTE_FULL, BYTE_FULL, BYTE_FULL);
      p.header[0] = ~p.header[0];
      packet_queue.push_back(p);
      p = make_packet(4'h5, 8'h11, 8'h22, 8'h33, 8'h44);
      p.header[3] = ~p.header[3];
      packet_queue.push_back(p);
      // foreign, and foreign wins over emergency
      packet_queue.push_back(make_packet(4'h0, 8'h00, 8'h00, 8'h00, 8'h00));
      packet_queue.push_back(make_packet(4'h3, BYTE_FULL, 8'h00, 8'h00, 8'h00));
      packet_queue.push_back(make_packet(4'hC, 8'h5A, 8'h00, 8'h00, 8'h00));
      // store then an emergency on the same slot must leave the entry alone; more emergencies on other slots
      packet_queue.push_back(make_packet(4'h5, 8'hAA, 8'h55, 8'hC3, 8'h3C));
      packet_queue.push_back(make_packet(4'h5, BYTE_FULL, 8'h01, 8'h02, 8'h03));
      packet_queue.push_back(make_packet(4'h6, 8'h10, BYTE_FULL, 8'h00, 8'h00));
      packet_queue.push_back(make_packet(4'h7, 8'h10, 8'h00, BYTE_FULL, 8'h00));
      packet_queue.push_back(make_packet(4'hF, 8'h10, 8'h20, 8'h30, BYTE_FULL));
      packet_queue.push_back(make_packet(4'h0, BYTE_FULL, BYTE_FULL, BYTE_FULL, BYTE_FULL));
      packet_queue.push_back(make_read(4'h5));
      // y and z zero with nonzero header and t: a regular store
      packet_queue.push_back(make_packet(4'h8, 8'h00, 8'h00, 8'h00, 8'hFE));
      packet_queue.push_back(make_read(4'h8));
      packet_queue.push_back(make_read(4'h6));
      wait_drained();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         send_idle_pct = phase_send[ph];
         recv_stall_pct = phase_recv[ph];
         for (int n = 0; n < PHASE_ITEMS; n++)
            packet_queue.push_back(random_item());
         // sender holds off here until every transaction has come back
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0 && expected_verdicts.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
